### hw/rtl/dstof_pkg.sv
// Shared types and constants for the two-way ranging time-of-flight block.
package dstof_pkg;

    localparam int QBITS       = 33;
    localparam int FLIGHT_W    = 32;
    localparam int DIST_W      = 52;
    localparam int SCALE_W     = 20;
    localparam int STAMP_W     = 32;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd307387;
    localparam logic [FLIGHT_W-1:0] FLIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [FLIGHT_W-1:0] FLIGHT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic v;
        logic neg;
        logic ovf;
        logic zero;
    } div_ctl_t;

endpackage

### hw/rtl/dstof_div_cell.sv
// One restoring-division cell: produces one quotient bit per beat.
module dstof_div_cell #(
    parameter int W = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dstof_pkg::div_ctl_t          ctl_in,
    input  logic [W+1:0]                 den_in,
    input  logic [W+1:0]                 rem_in,
    input  logic [dstof_pkg::QBITS-1:0]  bits_in,
    input  logic                         hold_in,
    output dstof_pkg::div_ctl_t          ctl_out,
    output logic [W+1:0]                 den_out,
    output logic [W+1:0]                 rem_out,
    output logic [dstof_pkg::QBITS-1:0]  bits_out,
    output logic                         hold_out
);
    import dstof_pkg::*;

    div_ctl_t           ctl_reg;
    logic [W+1:0]       den_reg;
    logic [W+1:0]       rem_reg;
    logic [QBITS-1:0]   bits_reg;
    logic [W+1:0]       rem_next;
    logic [QBITS-1:0]   bits_next;
    logic [W+3:0]       diff;
    logic               ge;

    assign diff      = {1'b0, rem_in, bits_in[QBITS-1]} - {2'b00, den_in};
    assign ge        = ~diff[W+3];
    assign rem_next  = ge ? diff[W+1:0] : {rem_in[W:0], bits_in[QBITS-1]};
    assign bits_next = {bits_in[QBITS-2:0], ge};
    assign hold_out  = ctl_reg.v & hold_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (!hold_out)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_out)
        begin
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign bits_out = bits_reg;

endmodule

### hw/rtl/dstof_prep.sv
// Interval, product, difference and overflow-check stages ahead of the divider.
module dstof_prep #(
    parameter int W = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [dstof_pkg::STAMP_W-1:0] poll_sent,
    input  logic [dstof_pkg::STAMP_W-1:0] poll_heard,
    input  logic [dstof_pkg::STAMP_W-1:0] reply_sent,
    input  logic [dstof_pkg::STAMP_W-1:0] reply_heard,
    input  logic [dstof_pkg::STAMP_W-1:0] last_sent,
    input  logic [dstof_pkg::STAMP_W-1:0] last_heard,
    input  logic                         hold_in,
    output dstof_pkg::div_ctl_t          ctl_out,
    output logic [W+1:0]                 den_out,
    output logic [W+1:0]                 rem_out,
    output logic [dstof_pkg::QBITS-1:0]  bits_out
);
    import dstof_pkg::*;

    localparam int H  = (W + 1) / 2;
    localparam int HH = 2 * H;
    localparam int PW = 2 * W;
    localparam int XW = PW + QBITS + 2;
    localparam int DW = W + 2;

    logic [STAMP_W-1:0] raw [6];
    logic [W-1:0]       st  [6];

    assign raw[0] = poll_sent;
    assign raw[1] = poll_heard;
    assign raw[2] = reply_sent;
    assign raw[3] = reply_heard;
    assign raw[4] = last_sent;
    assign raw[5] = last_heard;

    for (genvar i = 0; i < 6; i++)
    begin : g_stamp
        if (W <= STAMP_W)
        begin : g_cut
            assign st[i] = raw[i][W-1:0];
        end
        else
        begin : g_ext
            assign st[i] = W'(raw[i]);
        end
    end

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic h0, h1, h2, h3, h4;

    assign h4 = v4_reg & hold_in;
    assign h3 = v3_reg & h4;
    assign h2 = v2_reg & h3;
    assign h1 = v1_reg & h2;
    assign h0 = v0_reg & h1;
    assign in_stall = h0;

    // intervals
    logic [W-1:0]  ra_reg, rb_reg, da_reg, db_reg;
    logic [DW-1:0] den0_reg;
    logic [W-1:0]  ra_next, rb_next, da_next, db_next;

    assign ra_next = st[3] - st[0];
    assign rb_next = st[5] - st[2];
    assign da_next = st[4] - st[3];
    assign db_next = st[2] - st[1];

    // partial products
    logic [HH-1:0] rax, rbx, dax, dbx;
    logic [HH-1:0] prll_reg, prlh_reg, prhl_reg, prhh_reg;
    logic [HH-1:0] pdll_reg, pdlh_reg, pdhl_reg, pdhh_reg;
    logic [DW-1:0] den1_reg;

    assign rax = HH'(ra_reg);
    assign rbx = HH'(rb_reg);
    assign dax = HH'(da_reg);
    assign dbx = HH'(db_reg);

    // full products
    logic [PW-1:0] pr_reg, pd_reg;
    logic [DW-1:0] den2_reg;
    logic [PW-1:0] pr_next, pd_next;

    assign pr_next = PW'(prll_reg) + (PW'(PW'(prlh_reg) + PW'(prhl_reg)) << H)
                   + (PW'(prhh_reg) << HH);
    assign pd_next = PW'(pdll_reg) + (PW'(PW'(pdlh_reg) + PW'(pdhl_reg)) << H)
                   + (PW'(pdhh_reg) << HH);

    // magnitude and sign
    logic [PW-1:0] mag_reg;
    logic          neg_reg;
    logic [DW-1:0] den3_reg;

    // overflow check and divider seed
    logic [XW-1:0]        magx;
    logic [XW-QBITS-1:0]  hi;
    div_ctl_t             ctl4_reg;
    logic [DW-1:0]        den4_reg;
    logic [DW-1:0]        rem4_reg;
    logic [QBITS-1:0]     bits4_reg;

    assign magx = XW'(mag_reg);
    assign hi   = magx[XW-1:QBITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (!h0) v0_reg <= in_valid;
            if (!h1) v1_reg <= v0_reg;
            if (!h2) v2_reg <= v1_reg;
            if (!h3) v3_reg <= v2_reg;
            if (!h4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!h0)
        begin
            ra_reg   <= ra_next;
            rb_reg   <= rb_next;
            da_reg   <= da_next;
            db_reg   <= db_next;
            den0_reg <= DW'(ra_next) + DW'(rb_next) + DW'(da_next) + DW'(db_next);
        end
        if (!h1)
        begin
            prll_reg <= rax[H-1:0] * rbx[H-1:0];
            prlh_reg <= rax[H-1:0] * rbx[HH-1:H];
            prhl_reg <= rax[HH-1:H] * rbx[H-1:0];
            prhh_reg <= rax[HH-1:H] * rbx[HH-1:H];
            pdll_reg <= dax[H-1:0] * dbx[H-1:0];
            pdlh_reg <= dax[H-1:0] * dbx[HH-1:H];
            pdhl_reg <= dax[HH-1:H] * dbx[H-1:0];
            pdhh_reg <= dax[HH-1:H] * dbx[HH-1:H];
            den1_reg <= den0_reg;
        end
        if (!h2)
        begin
            pr_reg   <= pr_next;
            pd_reg   <= pd_next;
            den2_reg <= den1_reg;
        end
        if (!h3)
        begin
            neg_reg  <= pr_reg < pd_reg;
            mag_reg  <= (pr_reg < pd_reg) ? (pd_reg - pr_reg) : (pr_reg - pd_reg);
            den3_reg <= den2_reg;
        end
        if (!h4)
        begin
            ctl4_reg.v    <= v3_reg;
            ctl4_reg.neg  <= neg_reg;
            ctl4_reg.ovf  <= hi >= (XW - QBITS)'(den3_reg);
            ctl4_reg.zero <= den3_reg == '0;
            den4_reg      <= den3_reg;
            rem4_reg      <= hi[DW-1:0];
            bits4_reg     <= magx[QBITS-1:0];
        end
    end

    always_comb
    begin
        ctl_out   = ctl4_reg;
        ctl_out.v = v4_reg;
    end

    assign den_out  = den4_reg;
    assign rem_out  = rem4_reg;
    assign bits_out = bits4_reg;

endmodule

### hw/rtl/dstof_post.sv
// Sign, saturation and distance scaling after the divider; holds the output beat.
module dstof_post (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dstof_pkg::div_ctl_t                 ctl_in,
    input  logic [dstof_pkg::QBITS-1:0]         bits_in,
    input  logic [dstof_pkg::SCALE_W-1:0]       scale,
    output logic                                hold_out,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dstof_pkg::FLIGHT_W-1:0] flight_ticks,
    output logic signed [dstof_pkg::DIST_W-1:0]   distance_q16,
    output logic                                valid_res,
    output logic                                saturated
);
    import dstof_pkg::*;

    logic                v1_reg, v2_reg;
    logic                h1, h2;
    logic [FLIGHT_W-1:0] flight_reg, flight_next;
    logic                good_reg, sat_reg, sat_next;
    logic                good2_reg, sat2_reg;
    logic [FLIGHT_W-1:0] flight2_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic signed [FLIGHT_W+SCALE_W:0] prod;

    assign h2       = v2_reg & out_stall;
    assign h1       = v1_reg & h2;
    assign hold_out = ctl_in.v & h1;

    always_comb
    begin
        sat_next    = 1'b0;
        flight_next = '0;
        if (!ctl_in.zero)
        begin
            if (ctl_in.neg)
            begin
                sat_next    = ctl_in.ovf || (bits_in > QBITS'(FLIGHT_MIN));
                flight_next = sat_next ? FLIGHT_MIN : -bits_in[FLIGHT_W-1:0];
            end
            else
            begin
                sat_next    = ctl_in.ovf || (bits_in > QBITS'(FLIGHT_MAX));
                flight_next = sat_next ? FLIGHT_MAX : bits_in[FLIGHT_W-1:0];
            end
        end
    end

    assign prod = $signed(flight_reg) * $signed({1'b0, scale});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (!h1) v1_reg <= ctl_in.v;
            if (!h2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!h1)
        begin
            flight_reg <= flight_next;
            sat_reg    <= sat_next;
            good_reg   <= ~ctl_in.zero;
        end
        if (!h2)
        begin
            flight2_reg <= flight_reg;
            dist_reg    <= prod[DIST_W-1:0];
            good2_reg   <= good_reg;
            sat2_reg    <= sat_reg;
        end
    end

    assign out_valid    = v2_reg;
    assign flight_ticks = flight2_reg;
    assign distance_q16 = dist_reg;
    assign valid_res    = good2_reg;
    assign saturated    = sat2_reg;

endmodule

### hw/rtl/ds_twr_time_of_flight_top.sv
// Stages from input beat to output beat: 5 front stages, 33 divider cells, 2 back.
// Throughput: one exchange per cycle while no stall holds the pipeline; every stage holds one beat in flight.
// The row of division cells yields one quotient bit per cell.
// A stall holds only the filled stages ahead of it; empty stages keep filling.
// Reset clears all stage valid flags and loads scale_reg with 307387.
// Top level of the double-sided two-way ranging time-of-flight block.
module ds_twr_time_of_flight_top #(
    parameter int STAMP_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [dstof_pkg::STAMP_W-1:0]         poll_sent,
    input  logic [dstof_pkg::STAMP_W-1:0]         poll_heard,
    input  logic [dstof_pkg::STAMP_W-1:0]         reply_sent,
    input  logic [dstof_pkg::STAMP_W-1:0]         reply_heard,
    input  logic [dstof_pkg::STAMP_W-1:0]         last_sent,
    input  logic [dstof_pkg::STAMP_W-1:0]         last_heard,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [dstof_pkg::FLIGHT_W-1:0] flight_ticks,
    output logic signed [dstof_pkg::DIST_W-1:0]   distance_q16,
    output logic                                  valid_res,
    output logic                                  saturated,
    input  logic                                  cfg_we,
    input  logic [dstof_pkg::SCALE_W-1:0]         cfg_data
);
    import dstof_pkg::*;

    localparam int W  = STAMP_BITS;
    localparam int DW = W + 2;

    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_data;
        end
    end

    div_ctl_t         ctl  [QBITS+1];
    logic [DW-1:0]    den  [QBITS+1];
    logic [DW-1:0]    rem  [QBITS+1];
    logic [QBITS-1:0] bits [QBITS+1];
    logic             hold [QBITS+1];

    dstof_prep #(.W(W)) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .poll_sent   (poll_sent),
        .poll_heard  (poll_heard),
        .reply_sent  (reply_sent),
        .reply_heard (reply_heard),
        .last_sent   (last_sent),
        .last_heard  (last_heard),
        .hold_in     (hold[0]),
        .ctl_out     (ctl[0]),
        .den_out     (den[0]),
        .rem_out     (rem[0]),
        .bits_out    (bits[0])
    );

    for (genvar i = 0; i < QBITS; i++)
    begin : g_cell
        dstof_div_cell #(.W(W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (ctl[i]),
            .den_in   (den[i]),
            .rem_in   (rem[i]),
            .bits_in  (bits[i]),
            .hold_in  (hold[i+1]),
            .ctl_out  (ctl[i+1]),
            .den_out  (den[i+1]),
            .rem_out  (rem[i+1]),
            .bits_out (bits[i+1]),
            .hold_out (hold[i])
        );
    end

    dstof_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_in       (ctl[QBITS]),
        .bits_in      (bits[QBITS]),
        .scale        (scale_reg),
        .hold_out     (hold[QBITS]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .flight_ticks (flight_ticks),
        .distance_q16 (distance_q16),
        .valid_res    (valid_res),
        .saturated    (saturated)
    );

    logic unused_tail;
    assign unused_tail = ^{den[QBITS], rem[QBITS]};

endmodule

### verif/ds_twr_time_of_flight_checker.sv
// Checker for the two-way ranging block: predicts each result beat and compares it.
module ds_twr_time_of_flight_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic [dstof_pkg::STAMP_W-1:0]         poll_sent,
    input  logic [dstof_pkg::STAMP_W-1:0]         poll_heard,
    input  logic [dstof_pkg::STAMP_W-1:0]         reply_sent,
    input  logic [dstof_pkg::STAMP_W-1:0]         reply_heard,
    input  logic [dstof_pkg::STAMP_W-1:0]         last_sent,
    input  logic [dstof_pkg::STAMP_W-1:0]         last_heard,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [dstof_pkg::FLIGHT_W-1:0] flight_ticks,
    input  logic signed [dstof_pkg::DIST_W-1:0]   distance_q16,
    input  logic                                  valid_res,
    input  logic                                  saturated,
    input  logic                                  cfg_we,
    input  logic [dstof_pkg::SCALE_W-1:0]         cfg_data,
    output int                                    errors,
    output int                                    pending
);
    import dstof_pkg::*;

    typedef struct {
        logic [FLIGHT_W-1:0] flight;
        logic [DIST_W-1:0]   dist_q16;
        logic                good;
        logic                clamp;
    } range_t;

    logic [SCALE_W-1:0] scale_reg;
    range_t             ranges_due[$];

    function automatic range_t compute_range(
        logic [31:0] ps, logic [31:0] ph, logic [31:0] rs,
        logic [31:0] rh, logic [31:0] ls, logic [31:0] lh,
        logic [SCALE_W-1:0] scale);
        logic [31:0]          ra, rb, da, db;
        logic [33:0]          den;
        logic signed [65:0]   num;
        logic [65:0]          mag;
        logic [65:0]          quo;
        logic signed [33:0]   fl;
        logic signed [63:0]   dist_full;
        range_t               r;
        ra = rh - ps;
        rb = lh - rs;
        da = ls - rh;
        db = rs - ph;
        den = 34'(ra) + 34'(rb) + 34'(da) + 34'(db);
        r = '{flight: '0, dist_q16: '0, good: 1'b0, clamp: 1'b0};
        if (den != 0)
        begin
            num = $signed({2'b00, 64'(ra) * 64'(rb)}) - $signed({2'b00, 64'(da) * 64'(db)});
            mag = num < 0 ? 66'(-num) : 66'(num);
            quo = mag / 66'(den);
            r.good = 1'b1;
            if (num < 0)
            begin
                if (quo > 66'd2147483648)
                begin
                    quo = 66'd2147483648;
                    r.clamp = 1'b1;
                end
                fl = -$signed({1'b0, quo[32:0]});
            end
            else
            begin
                if (quo > 66'd2147483647)
                begin
                    quo = 66'd2147483647;
                    r.clamp = 1'b1;
                end
                fl = $signed({1'b0, quo[32:0]});
            end
            dist_full = 64'(fl) * $signed({44'd0, scale});
            r.flight = fl[31:0];
            r.dist_q16 = dist_full[DIST_W-1:0];
        end
        return r;
    endfunction

    assign pending = ranges_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            errors <= 0;
        end
        else
        begin
            range_t got;
            if (cfg_we)
                scale_reg <= cfg_data;
            if (in_valid && !in_stall)
                ranges_due.push_back(compute_range(poll_sent, poll_heard, reply_sent,
                                                    reply_heard, last_sent, last_heard,
                                                    scale_reg));
            if (out_valid && !out_stall)
            begin
                if (ranges_due.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors <= errors + 1;
                end
                else
                begin
                    got = ranges_due.pop_front();
                    if (flight_ticks !== got.flight ||
                        distance_q16 !== got.dist_q16 ||
                        valid_res !== got.good || saturated !== got.clamp)
                        errors <= errors + 1;
                    if (flight_ticks !== got.flight)
                        $error("flight_ticks exp %0d got %0d",
                               $signed(got.flight), flight_ticks);
                    if (distance_q16 !== got.dist_q16)
                        $error("distance_q16 exp %0d got %0d",
                               $signed(got.dist_q16), distance_q16);
                    if (valid_res !== got.good)
                        $error("valid_res exp %0b got %0b", got.good, valid_res);
                    if (saturated !== got.clamp)
                        $error("saturated exp %0b got %0b", got.clamp, saturated);
                end
            end
        end
    end
endmodule

### verif/tb_ds_twr_time_of_flight_top.sv
// Testbench top for the two-way ranging block: stimulus, configuration and verdict.
module tb_ds_twr_time_of_flight_top;
    import dstof_pkg::*;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [STAMP_W-1:0]          poll_sent, poll_heard, reply_sent;
    logic [STAMP_W-1:0]          reply_heard, last_sent, last_heard;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [FLIGHT_W-1:0]  flight_ticks;
    logic signed [DIST_W-1:0]    distance_q16;
    logic                        valid_res;
    logic                        saturated;
    logic                        cfg_we;
    logic [SCALE_W-1:0]          cfg_data;
    int                          errors;
    int                          pending;
    logic                        sending_done;

    ds_twr_time_of_flight_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .poll_sent(poll_sent), .poll_heard(poll_heard), .reply_sent(reply_sent),
        .reply_heard(reply_heard), .last_sent(last_sent), .last_heard(last_heard),
        .out_valid(out_valid), .out_stall(out_stall),
        .flight_ticks(flight_ticks), .distance_q16(distance_q16),
        .valid_res(valid_res), .saturated(saturated),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    ds_twr_time_of_flight_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .poll_sent(poll_sent), .poll_heard(poll_heard), .reply_sent(reply_sent),
        .reply_heard(reply_heard), .last_sent(last_sent), .last_heard(last_heard),
        .out_valid(out_valid), .out_stall(out_stall),
        .flight_ticks(flight_ticks), .distance_q16(distance_q16),
        .valid_res(valid_res), .saturated(saturated),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("ds_twr_time_of_flight_top regression: fail");
        $finish;
    end

    // receiver: random stall lengths, sometimes no stall at all
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (out_valid && !out_stall)
            begin
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                if (hold != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_exchange(logic [31:0] ps, logic [31:0] ph, logic [31:0] rs,
                                 logic [31:0] rh, logic [31:0] ls, logic [31:0] lh,
                                 bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        poll_sent <= ps;
        poll_heard <= ph;
        reply_sent <= rs;
        reply_heard <= rh;
        last_sent <= ls;
        last_heard <= lh;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // well-formed exchange: small flight, realistic delays, random start so counters wrap
    task automatic send_realistic(bit calm);
        logic [31:0] t0, tof, dlyb, dlya, skew;
        t0 = $urandom();
        skew = $urandom();
        tof = $urandom_range(0, 5000);
        dlyb = $urandom_range(1, 1 << $urandom_range(1, 30));
        dlya = $urandom_range(1, 1 << $urandom_range(1, 30));
        send_exchange(t0, t0 + tof + skew, t0 + tof + skew + dlyb,
                      t0 + 2 * tof + dlyb, t0 + 2 * tof + dlyb + dlya,
                      t0 + 3 * tof + dlyb + dlya + skew + $urandom_range(0, 7), calm);
    endtask

    task automatic write_scale(logic [SCALE_W-1:0] v);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (45) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [SCALE_W-1:0] scales [5];
        int                 waited;
        scales = '{20'd0, 20'hFFFFF, 20'd1, 20'd65536, 20'd0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        sending_done = 1'b0;
        {poll_sent, poll_heard, reply_sent, reply_heard, last_sent, last_heard} = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_exchange(0, 0, 0, 0, 0, 0, 1);
        send_exchange('1, '1, '1, '1, '1, '1, 1);
        send_exchange(0, '1, '1, '1, '1, '1, 0);
        send_exchange(0, 0, 0, '1, '1, '1, 1);
        send_exchange('1, 0, 0, 0, 0, 0, 1);
        send_exchange(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE, '1, 1);
        send_exchange(0, 32'h8000_0000, 32'h8000_0001, 1, 2, 3, 0);
        send_exchange(0, 1, 2, '1, 32'hFFFF_FFFE, 32'hFFFF_FFF0, 1);
        send_exchange(32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h10, 32'h20, 32'h40, 32'h60, 1);
        send_exchange(100, 200, 300, 400, 500, 600, 0);
        send_exchange(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1);
        send_exchange(0, 0, 1, 0, 0, 1, 1);
        send_exchange(0, 0, 0, 1, 1, 0, 1);
        repeat (6) send_realistic(1);

        for (int phase = 0; phase < 5; phase++)
        begin
            write_scale(scales[phase] ^ (phase == 4 ? 20'($urandom()) : 20'd0));
            for (int n = 0; n < 400; n++)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_realistic(n % 50 < 10);
                else
                    send_exchange($urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom(), n % 50 < 10);
            end
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;

        waited = 0;
        while (pending != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (50) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("ds_twr_time_of_flight_top regression: pass");
        else
            $display("ds_twr_time_of_flight_top regression: fail");
        $finish;
    end
endmodule

### files.f
hw/rtl/dstof_pkg.sv
hw/rtl/dstof_div_cell.sv
hw/rtl/dstof_prep.sv
hw/rtl/dstof_post.sv
hw/rtl/ds_twr_time_of_flight_top.sv
verif/ds_twr_time_of_flight_checker.sv
verif/tb_ds_twr_time_of_flight_top.sv
